>>> hw/rtl/cdtl_pkg.sv
// shared types and constants of the cube map direction texel lookup
package cdtl_pkg;

    localparam int NUM_FACES = 6;

    localparam int DIR_W   = 16;
    localparam int COORD_W = DIR_W + 1;      // signed face coordinate, holds negated -32768
    localparam int DEN_W   = DIR_W + 1;      // 2m, up to 65536
    localparam int SIZE_W  = 7;              // face_width / face_height registers
    localparam int NUM_W   = 24;             // (s+m)*n, below 2^23
    localparam int Q_W     = 7;              // quotient never exceeds n, n below 128
    localparam int FACE_W  = 3;
    localparam int TCOL_W  = 6;              // wr_col / col / row fields
    localparam int COLOR_W = 24;

    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_FACE_WIDTH  = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_FACE_HEIGHT = 1'd1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef enum logic [FACE_W-1:0] {
        FACE_NEG_X = 3'd0,
        FACE_NEG_Y = 3'd1,
        FACE_NEG_Z = 3'd2,
        FACE_POS_X = 3'd3,
        FACE_POS_Y = 3'd4,
        FACE_POS_Z = 3'd5
    } t_face;

    // fields that ride along with a transaction through the pipeline
    typedef struct packed {
        t_op                 op;
        logic                zero;
        t_face               face;
        logic [FACE_W-1:0]   wr_face;
        logic [TCOL_W-1:0]   wr_col;
        logic [TCOL_W-1:0]   wr_row;
        logic [COLOR_W-1:0]  wr_color;
    } t_side;

    // front end to divider
    typedef struct packed {
        logic [NUM_W-1:0] num_s;
        logic [NUM_W-1:0] num_t;
        logic [DEN_W-1:0] den;
        t_side            side;
    } t_div_in;

    // divider to memory stage
    typedef struct packed {
        logic [Q_W-1:0] q_s;
        logic [Q_W-1:0] q_t;
        t_side          side;
    } t_div_out;

endpackage

>>> hw/rtl/cdtl_ram.sv
// generic single-clock ram, one write and one registered read port
module cdtl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 24576
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/cdtl_front.sv
// face selection and numerator product, two pipeline stages
module cdtl_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  cdtl_pkg::t_op                i_op,
    input  logic [cdtl_pkg::DIR_W-1:0]   i_dir_x,
    input  logic [cdtl_pkg::DIR_W-1:0]   i_dir_y,
    input  logic [cdtl_pkg::DIR_W-1:0]   i_dir_z,
    input  logic [cdtl_pkg::FACE_W-1:0]  i_wr_face,
    input  logic [cdtl_pkg::TCOL_W-1:0]  i_wr_col,
    input  logic [cdtl_pkg::TCOL_W-1:0]  i_wr_row,
    input  logic [cdtl_pkg::COLOR_W-1:0] i_wr_color,
    input  logic [cdtl_pkg::SIZE_W-1:0]  i_width,
    input  logic [cdtl_pkg::SIZE_W-1:0]  i_height,
    output logic                         o_valid,
    input  logic                         i_ready,
    output cdtl_pkg::t_div_in            o_data
);

    typedef struct packed {
        logic signed [cdtl_pkg::COORD_W-1:0] s;
        logic signed [cdtl_pkg::COORD_W-1:0] t;
        logic [cdtl_pkg::COORD_W-1:0]        m;
        cdtl_pkg::t_side                     side;
    } t_sel;

    logic signed [cdtl_pkg::COORD_W-1:0] vx, vy, vz;
    logic [cdtl_pkg::COORD_W-1:0]        ax, ay, az;
    logic [1:0]                          dim;
    logic                                pos;
    t_sel                                n_sel, r_sel;
    cdtl_pkg::t_div_in                   n_prod, r_prod;
    logic                                r_vld_sel, r_vld_prod;
    logic                                ld_sel, ld_prod;
    logic signed [cdtl_pkg::COORD_W:0]   sum_s, sum_t;
    logic [cdtl_pkg::COORD_W-1:0]        us, ut;

    // stage 1: dominant axis, face, face coordinates
    always_comb begin
        vx = cdtl_pkg::COORD_W'($signed(i_dir_x));
        vy = cdtl_pkg::COORD_W'($signed(i_dir_y));
        vz = cdtl_pkg::COORD_W'($signed(i_dir_z));
        ax = (vx < 0) ? cdtl_pkg::COORD_W'(-vx) : cdtl_pkg::COORD_W'(vx);
        ay = (vy < 0) ? cdtl_pkg::COORD_W'(-vy) : cdtl_pkg::COORD_W'(vy);
        az = (vz < 0) ? cdtl_pkg::COORD_W'(-vz) : cdtl_pkg::COORD_W'(vz);

        // lowest axis wins a tie
        dim = 2'd0;
        n_sel.m = ax;
        if (ay > n_sel.m) begin
            dim = 2'd1;
            n_sel.m = ay;
        end
        if (az > n_sel.m) begin
            dim = 2'd2;
            n_sel.m = az;
        end

        n_sel.side.op       = i_op;
        n_sel.side.zero     = (n_sel.m == '0);
        n_sel.side.wr_face  = i_wr_face;
        n_sel.side.wr_col   = i_wr_col;
        n_sel.side.wr_row   = i_wr_row;
        n_sel.side.wr_color = i_wr_color;

        case (dim)
            2'd0:    pos = (vx > 0);
            2'd1:    pos = (vy > 0);
            default: pos = (vz > 0);
        endcase

        case (dim)
            2'd0: begin
                n_sel.side.face = pos ? cdtl_pkg::FACE_POS_X : cdtl_pkg::FACE_NEG_X;
                n_sel.s = pos ? -vz : vz;
                n_sel.t = -vy;
            end
            2'd1: begin
                n_sel.side.face = pos ? cdtl_pkg::FACE_POS_Y : cdtl_pkg::FACE_NEG_Y;
                n_sel.s = vx;
                n_sel.t = pos ? vz : -vz;
            end
            default: begin
                n_sel.side.face = pos ? cdtl_pkg::FACE_POS_Z : cdtl_pkg::FACE_NEG_Z;
                n_sel.s = vx;
                n_sel.t = pos ? -vy : vy;
            end
        endcase
    end

    // stage 2: (c+m)*n and 2m
    always_comb begin
        sum_s = (cdtl_pkg::COORD_W+1)'(r_sel.s) + $signed({2'b00, r_sel.m[cdtl_pkg::COORD_W-2:0]})
              + $signed({1'b0, r_sel.m[cdtl_pkg::COORD_W-1], {(cdtl_pkg::COORD_W-1){1'b0}}});
        sum_t = (cdtl_pkg::COORD_W+1)'(r_sel.t) + $signed({2'b00, r_sel.m[cdtl_pkg::COORD_W-2:0]})
              + $signed({1'b0, r_sel.m[cdtl_pkg::COORD_W-1], {(cdtl_pkg::COORD_W-1){1'b0}}});
        us = sum_s[cdtl_pkg::COORD_W-1:0];
        ut = sum_t[cdtl_pkg::COORD_W-1:0];
        n_prod.num_s = cdtl_pkg::NUM_W'(us) * cdtl_pkg::NUM_W'(i_width);
        n_prod.num_t = cdtl_pkg::NUM_W'(ut) * cdtl_pkg::NUM_W'(i_height);
        n_prod.den   = cdtl_pkg::DEN_W'({r_sel.m, 1'b0});
        n_prod.side  = r_sel.side;
    end

    // bubbles collapse: a stage loads when empty or when its content moves on
    assign ld_prod = !r_vld_prod || i_ready;
    assign ld_sel  = !r_vld_sel || ld_prod;
    assign o_ready = ld_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_sel  <= 1'b0;
            r_vld_prod <= 1'b0;
        end else begin
            if (ld_sel) begin
                r_vld_sel <= i_valid;
            end
            if (ld_prod) begin
                r_vld_prod <= r_vld_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_sel) begin
            r_sel <= n_sel;
        end
        if (ld_prod) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_vld_prod;
    assign o_data  = r_prod;

endmodule

>>> hw/rtl/cdtl_div.sv
// two-lane restoring divider, one quotient bit per pipeline stage
module cdtl_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  cdtl_pkg::t_div_in  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output cdtl_pkg::t_div_out o_data
);

    typedef struct packed {
        logic [cdtl_pkg::NUM_W-1:0] rem_s;
        logic [cdtl_pkg::NUM_W-1:0] rem_t;
        logic [cdtl_pkg::Q_W-1:0]   q_s;
        logic [cdtl_pkg::Q_W-1:0]   q_t;
        logic [cdtl_pkg::DEN_W-1:0] den;
        cdtl_pkg::t_side            side;
    } t_div_stage;

    function automatic t_div_stage div_step(input t_div_stage a, input int unsigned bitpos);
        t_div_stage                 r;
        logic [cdtl_pkg::NUM_W-1:0] trial;
        trial = cdtl_pkg::NUM_W'(a.den) << bitpos;
        r = a;
        if (a.rem_s >= trial) begin
            r.rem_s = a.rem_s - trial;
            r.q_s   = {a.q_s[cdtl_pkg::Q_W-2:0], 1'b1};
        end else begin
            r.q_s   = {a.q_s[cdtl_pkg::Q_W-2:0], 1'b0};
        end
        if (a.rem_t >= trial) begin
            r.rem_t = a.rem_t - trial;
            r.q_t   = {a.q_t[cdtl_pkg::Q_W-2:0], 1'b1};
        end else begin
            r.q_t   = {a.q_t[cdtl_pkg::Q_W-2:0], 1'b0};
        end
        return r;
    endfunction

    t_div_stage               init;
    t_div_stage               n_stg [cdtl_pkg::Q_W];
    t_div_stage               r_stg [cdtl_pkg::Q_W];
    logic [cdtl_pkg::Q_W-1:0] r_vld;
    logic [cdtl_pkg::Q_W:0]   ld;

    always_comb begin
        init.rem_s = i_data.num_s;
        init.rem_t = i_data.num_t;
        init.q_s   = '0;
        init.q_t   = '0;
        init.den   = i_data.den;
        init.side  = i_data.side;
        for (int k = 0; k < cdtl_pkg::Q_W; k++) begin
            n_stg[k] = div_step((k == 0) ? init : r_stg[(k == 0) ? 0 : k-1],
                                cdtl_pkg::Q_W - 1 - k);
        end
    end

    always_comb begin
        ld[cdtl_pkg::Q_W] = i_ready;
        for (int k = cdtl_pkg::Q_W - 1; k >= 0; k--) begin
            ld[k] = !r_vld[k] || ld[k+1];
        end
    end

    assign o_ready = ld[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < cdtl_pkg::Q_W; k++) begin
                if (ld[k]) begin
                    r_vld[k] <= (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < cdtl_pkg::Q_W; k++) begin
            if (ld[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_valid     = r_vld[cdtl_pkg::Q_W-1];
    assign o_data.q_s  = r_stg[cdtl_pkg::Q_W-1].q_s;
    assign o_data.q_t  = r_stg[cdtl_pkg::Q_W-1].q_t;
    assign o_data.side = r_stg[cdtl_pkg::Q_W-1].side;

endmodule

>>> hw/rtl/cubemap_direction_texel_lookup.sv
// top level of the cube map direction texel lookup
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+------------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready    | tdata: write fields or direction, tuser: op
//  m_axis   | out | m_axis_tvalid/tready    | tdata: color, face, col, row, tuser: zero_dir
//  cfg      | in  | i_cfg_we                | i_cfg_idx selects face_width / face_height
//
// one transaction per cycle in both directions while m_axis_tready stays high; 10 register
// stages: 2 front, 7 divider (one quotient bit each), 1 ram read with the output fields
// texel writes and lookups both reach the ram in the last stage, so they stay in order
// reset clears valid bits and sets the size registers to 64; texel ram is not cleared
// stalls collapse bubbles stage by stage, ready ripples back from m_axis_tready
module cubemap_direction_texel_lookup #(
    parameter int FACE_SIZE = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // dir_x, dir_y, dir_z, wr_face, wr_col, wr_row, wr_color, zero pad
    input  logic [87:0]                       s_axis_tdata,
    // op
    input  logic                              s_axis_tuser,

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // color, face, col, row, zero pad
    output logic [39:0]                       m_axis_tdata,
    // zero_dir
    output logic                              m_axis_tuser,

    input  logic                              i_cfg_we,
    input  logic [cdtl_pkg::REG_IDX_W-1:0]    i_cfg_idx,
    input  logic [cdtl_pkg::SIZE_W-1:0]       i_cfg_data
);

    localparam int FACE_TEXELS = FACE_SIZE * FACE_SIZE;
    localparam int DEPTH       = cdtl_pkg::NUM_FACES * FACE_TEXELS;
    localparam int AW          = $clog2(DEPTH);
    // largest size a 7-bit register can reach once clamped to the face
    localparam logic [cdtl_pkg::SIZE_W-1:0] SIZE_CAP =
        (FACE_SIZE > 127) ? 7'd127 : cdtl_pkg::SIZE_W'(FACE_SIZE);

    // size registers
    logic [cdtl_pkg::SIZE_W-1:0] r_face_width, r_face_height;
    logic [cdtl_pkg::SIZE_W-1:0] eff_w, eff_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_width  <= cdtl_pkg::SIZE_RESET;
            r_face_height <= cdtl_pkg::SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cdtl_pkg::REG_FACE_WIDTH:  r_face_width  <= i_cfg_data;
                cdtl_pkg::REG_FACE_HEIGHT: r_face_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero acts as one, anything above the face as the face size
    assign eff_w = (r_face_width == '0) ? cdtl_pkg::SIZE_W'(1)
                 : ((r_face_width > SIZE_CAP) ? SIZE_CAP : r_face_width);
    assign eff_h = (r_face_height == '0) ? cdtl_pkg::SIZE_W'(1)
                 : ((r_face_height > SIZE_CAP) ? SIZE_CAP : r_face_height);

    // front end: face select and numerators
    logic               front_vld, front_rdy;
    cdtl_pkg::t_div_in  front_data;

    cdtl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_op       (cdtl_pkg::t_op'(s_axis_tuser)),
        .i_dir_x    (s_axis_tdata[15:0]),
        .i_dir_y    (s_axis_tdata[31:16]),
        .i_dir_z    (s_axis_tdata[47:32]),
        .i_wr_face  (s_axis_tdata[50:48]),
        .i_wr_col   (s_axis_tdata[56:51]),
        .i_wr_row   (s_axis_tdata[62:57]),
        .i_wr_color (s_axis_tdata[86:63]),
        .i_width    (eff_w),
        .i_height   (eff_h),
        .o_valid    (front_vld),
        .i_ready    (front_rdy),
        .o_data     (front_data)
    );

    // quotient pipeline
    logic               div_vld;
    cdtl_pkg::t_div_out div_data;
    logic               ld_out;

    cdtl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_vld),
        .o_ready (front_rdy),
        .i_data  (front_data),
        .o_valid (div_vld),
        .i_ready (ld_out),
        .o_data  (div_data)
    );

    // memory stage: clamp, address, write or read
    logic [cdtl_pkg::Q_W-1:0]     col_c, row_c;
    logic                         is_lookup, wr_ok, enter, ram_we;
    logic [AW-1:0]                addr;
    logic [cdtl_pkg::COLOR_W-1:0] ram_rdata;

    // quotient equal to the size clamps to the last texel
    assign col_c = (div_data.q_s >= eff_w) ? (eff_w - 1'b1) : div_data.q_s;
    assign row_c = (div_data.q_t >= eff_h) ? (eff_h - 1'b1) : div_data.q_t;

    assign is_lookup = (div_data.side.op == cdtl_pkg::OP_LOOKUP);
    // writes outside the store are dropped
    assign wr_ok = (div_data.side.wr_face < cdtl_pkg::FACE_W'(cdtl_pkg::NUM_FACES))
                && (32'(div_data.side.wr_col) < FACE_SIZE)
                && (32'(div_data.side.wr_row) < FACE_SIZE);

    always_comb begin
        if (is_lookup) begin
            addr = AW'(div_data.side.face) * AW'(FACE_TEXELS)
                 + AW'(row_c) * AW'(FACE_SIZE) + AW'(col_c);
        end else begin
            addr = AW'(div_data.side.wr_face) * AW'(FACE_TEXELS)
                 + AW'(div_data.side.wr_row) * AW'(FACE_SIZE) + AW'(div_data.side.wr_col);
        end
    end

    logic                          r_out_vld;
    logic                          r_out_color_en;
    logic [cdtl_pkg::FACE_W-1:0]   r_out_face;
    logic [cdtl_pkg::TCOL_W-1:0]   r_out_col, r_out_row;
    logic                          r_out_zero;

    assign ld_out = !r_out_vld || m_axis_tready;
    assign enter  = div_vld && ld_out;
    assign ram_we = enter && !is_lookup && wr_ok;

    cdtl_ram #(
        .WIDTH (cdtl_pkg::COLOR_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (addr),
        .i_wdata (div_data.side.wr_color),
        .i_re    (ld_out),
        .i_raddr (addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (ld_out) begin
            r_out_vld <= div_vld;
        end
    end

    // writes and zero vectors report all-zero fields
    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out_color_en <= is_lookup && !div_data.side.zero;
            r_out_zero     <= is_lookup && div_data.side.zero;
            if (is_lookup && !div_data.side.zero) begin
                r_out_face <= div_data.side.face;
                r_out_col  <= col_c[cdtl_pkg::TCOL_W-1:0];
                r_out_row  <= row_c[cdtl_pkg::TCOL_W-1:0];
            end else begin
                r_out_face <= '0;
                r_out_col  <= '0;
                r_out_row  <= '0;
            end
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out_row, r_out_col, r_out_face,
                            r_out_color_en ? ram_rdata : {cdtl_pkg::COLOR_W{1'b0}}};
    assign m_axis_tuser  = r_out_zero;

endmodule

>>> tb/sv/tb_cubemap_direction_texel_lookup.sv
// self-checking testbench for the cube map direction texel lookup
`timescale 1ns / 100ps

module tb_cubemap_direction_texel_lookup;

    localparam int FACE_SIZE    = 64;
    localparam int FACE_TEXELS  = FACE_SIZE * FACE_SIZE;
    localparam int PIPE_LATENCY = 9;       // accepting edge to m_axis_tvalid
    localparam int HOLD_CYCLES  = 150;     // long sink hold-off, well past pipeline depth
    localparam int STALL_LIMIT  = 4000;    // cycles without any transaction before giving up
    localparam int MAX_REPORTS  = 10;

    // bit positions of the result fields inside m_axis_tdata
    localparam int FACE_LSB = cdtl_pkg::COLOR_W;
    localparam int COL_LSB  = FACE_LSB + cdtl_pkg::FACE_W;
    localparam int ROW_LSB  = COL_LSB + cdtl_pkg::TCOL_W;

    // one input item, unpacked
    typedef struct {
        cdtl_pkg::t_op                op;
        logic signed [15:0]           dir_x;
        logic signed [15:0]           dir_y;
        logic signed [15:0]           dir_z;
        logic [cdtl_pkg::FACE_W-1:0]  wr_face;
        logic [cdtl_pkg::TCOL_W-1:0]  wr_col;
        logic [cdtl_pkg::TCOL_W-1:0]  wr_row;
        logic [cdtl_pkg::COLOR_W-1:0] wr_color;
    } t_texel_req;

    // one result item as it should leave the block
    typedef struct packed {
        logic                         zero_dir;
        logic [cdtl_pkg::TCOL_W-1:0]  row;
        logic [cdtl_pkg::TCOL_W-1:0]  col;
        logic [cdtl_pkg::FACE_W-1:0]  face;
        logic [cdtl_pkg::COLOR_W-1:0] color;
    } t_texel_result;

    // where a direction lands on the cube
    typedef struct {
        bit              zero;
        cdtl_pkg::t_face face;
        int unsigned     col;
        int unsigned     row;
    } t_cube_hit;

    // clock, reset and block ports; every input known from time zero
    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // dir_x, dir_y, dir_z, wr_face, wr_col, wr_row, wr_color, zero pad
    logic [87:0]                    s_axis_tdata  = '0;
    // op
    logic                           s_axis_tuser  = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // color, face, col, row, zero pad
    logic [39:0]                    m_axis_tdata;
    // zero_dir
    logic                           m_axis_tuser;
    logic                           i_cfg_we      = 1'b0;
    logic [cdtl_pkg::REG_IDX_W-1:0] i_cfg_idx     = cdtl_pkg::REG_FACE_WIDTH;
    logic [cdtl_pkg::SIZE_W-1:0]    i_cfg_data    = '0;

    // predictor copy of the texel ram and the size registers
    logic [cdtl_pkg::COLOR_W-1:0] texel_mem   [cdtl_pkg::NUM_FACES*FACE_TEXELS];
    bit                           texel_known [cdtl_pkg::NUM_FACES*FACE_TEXELS];
    logic [cdtl_pkg::SIZE_W-1:0]  width_reg  = cdtl_pkg::SIZE_RESET;
    logic [cdtl_pkg::SIZE_W-1:0]  height_reg = cdtl_pkg::SIZE_RESET;
    t_texel_result                expected_q [$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;

    // sink side control, hold-off requests are counted so the sink process owns its timing
    bit sink_idle_on  = 1'b1;
    bit src_idle_on   = 1'b1;
    int hold_requests = 0;
    int holds_served  = 0;
    int sink_wait     = 0;

    cubemap_direction_texel_lookup #(
        .FACE_SIZE(FACE_SIZE)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // register value in use: zero acts as one, anything past the face acts as the face
    function automatic int unsigned span_of(input logic [cdtl_pkg::SIZE_W-1:0] r);
        if (r == 0)
            return 1;
        if (r > FACE_SIZE)
            return FACE_SIZE;
        return r;
    endfunction

    // floor((c+m)*n/(2m)), the far edge folds onto the last texel
    function automatic int unsigned texel_coord(input int c, input int m, input int unsigned n);
        longint unsigned q;
        q = (longint'(c + m) * longint'(n)) / (2 * longint'(m));
        if (q >= n)
            q = n - 1;
        return int'(q);
    endfunction

    function automatic int unsigned texel_addr(input int unsigned f, input int unsigned c,
                                               input int unsigned r);
        return f * FACE_TEXELS + r * FACE_SIZE + c;
    endfunction

    // major axis picks the face (lowest axis wins a tie), the other two give s and t
    function automatic t_cube_hit aim_direction(input logic signed [15:0] dx,
                                                input logic signed [15:0] dy,
                                                input logic signed [15:0] dz);
        t_cube_hit hit;
        int        v [3];
        int        a [3];
        int        dim;
        int        m;
        int        s;
        int        t;
        int        i;
        hit = '{zero: 1'b0, face: cdtl_pkg::FACE_NEG_X, col: 0, row: 0};
        v[0] = dx;
        v[1] = dy;
        v[2] = dz;
        for (i = 0; i < 3; i++)
            a[i] = (v[i] < 0) ? -v[i] : v[i];
        dim = 0;
        if (a[1] > a[dim])
            dim = 1;
        if (a[2] > a[dim])
            dim = 2;
        m = a[dim];
        if (m == 0) begin
            hit.zero = 1'b1;
            return hit;
        end
        case (dim)
            0:       hit.face = (v[0] > 0) ? cdtl_pkg::FACE_POS_X : cdtl_pkg::FACE_NEG_X;
            1:       hit.face = (v[1] > 0) ? cdtl_pkg::FACE_POS_Y : cdtl_pkg::FACE_NEG_Y;
            default: hit.face = (v[2] > 0) ? cdtl_pkg::FACE_POS_Z : cdtl_pkg::FACE_NEG_Z;
        endcase
        case (hit.face)
            cdtl_pkg::FACE_NEG_X: begin s =  v[2]; t = -v[1]; end
            cdtl_pkg::FACE_POS_X: begin s = -v[2]; t = -v[1]; end
            cdtl_pkg::FACE_NEG_Y: begin s =  v[0]; t = -v[2]; end
            cdtl_pkg::FACE_POS_Y: begin s =  v[0]; t =  v[2]; end
            cdtl_pkg::FACE_NEG_Z: begin s =  v[0]; t =  v[1]; end
            default:              begin s =  v[0]; t = -v[1]; end
        endcase
        hit.col = texel_coord(s, m, span_of(width_reg));
        hit.row = texel_coord(t, m, span_of(height_reg));
        return hit;
    endfunction

    // result of one item; a texel write also lands in the predictor ram
    function automatic t_texel_result predict_texel(input t_texel_req req);
        t_texel_result res;
        t_cube_hit     hit;
        int unsigned   addr;
        res = '0;
        if (req.op == cdtl_pkg::OP_WRITE) begin
            // out-of-range faces are dropped by the block
            if (req.wr_face < cdtl_pkg::NUM_FACES) begin
                addr              = texel_addr(req.wr_face, req.wr_col, req.wr_row);
                texel_mem[addr]   = req.wr_color;
                texel_known[addr] = 1'b1;
            end
        end else begin
            hit = aim_direction(req.dir_x, req.dir_y, req.dir_z);
            if (hit.zero) begin
                res.zero_dir = 1'b1;
            end else begin
                res.color = texel_mem[texel_addr(hit.face, hit.col, hit.row)];
                res.face  = hit.face;
                res.col   = cdtl_pkg::TCOL_W'(hit.col);
                res.row   = cdtl_pkg::TCOL_W'(hit.row);
            end
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // source side
    // ------------------------------------------------------------------

    // all fields random, callers override what matters
    function automatic t_texel_req random_req();
        t_texel_req req;
        req.op       = ($urandom_range(0, 1) != 0) ? cdtl_pkg::OP_LOOKUP : cdtl_pkg::OP_WRITE;
        req.dir_x    = 16'($urandom());
        req.dir_y    = 16'($urandom());
        req.dir_z    = 16'($urandom());
        req.wr_face  = cdtl_pkg::FACE_W'($urandom());
        req.wr_col   = cdtl_pkg::TCOL_W'($urandom());
        req.wr_row   = cdtl_pkg::TCOL_W'($urandom());
        req.wr_color = cdtl_pkg::COLOR_W'($urandom());
        return req;
    endfunction

    // offer one transaction and hold it until the block takes it; entered at a rising edge
    task automatic send_item(input t_texel_req req);
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        expected_q.push_back(predict_texel(req));
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req.op;
        s_axis_tdata  <= {1'b0, req.wr_color, req.wr_row, req.wr_col, req.wr_face,
                          req.dir_z, req.dir_y, req.dir_x};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
    endtask

    task automatic send_write(input logic [cdtl_pkg::FACE_W-1:0] f, input int unsigned c,
                              input int unsigned r,
                              input logic [cdtl_pkg::COLOR_W-1:0] color);
        t_texel_req req;
        req          = random_req();
        req.op       = cdtl_pkg::OP_WRITE;
        req.wr_face  = f;
        req.wr_col   = cdtl_pkg::TCOL_W'(c);
        req.wr_row   = cdtl_pkg::TCOL_W'(r);
        req.wr_color = color;
        send_item(req);
    endtask

    // a lookup never reads a texel that was never written: fill it first if needed
    task automatic send_lookup(input logic signed [15:0] dx, input logic signed [15:0] dy,
                               input logic signed [15:0] dz);
        t_texel_req req;
        t_cube_hit  hit;
        hit = aim_direction(dx, dy, dz);
        if (!hit.zero && !texel_known[texel_addr(hit.face, hit.col, hit.row)])
            send_write(hit.face, hit.col, hit.row, cdtl_pkg::COLOR_W'($urandom()));
        req       = random_req();
        req.op    = cdtl_pkg::OP_LOOKUP;
        req.dir_x = dx;
        req.dir_y = dy;
        req.dir_z = dz;
        send_item(req);
    endtask

    task automatic random_write();
        logic [cdtl_pkg::FACE_W-1:0] f;
        // mostly real faces, now and then one of the two unused codes
        if ($urandom_range(0, 9) == 0)
            f = cdtl_pkg::FACE_W'($urandom_range(cdtl_pkg::NUM_FACES,
                                                 (1 << cdtl_pkg::FACE_W) - 1));
        else
            f = cdtl_pkg::FACE_W'($urandom_range(0, cdtl_pkg::NUM_FACES - 1));
        send_write(f, $urandom_range(0, FACE_SIZE - 1), $urandom_range(0, FACE_SIZE - 1),
                   cdtl_pkg::COLOR_W'($urandom()));
    endtask

    // directions shaped to hit ties, extremes, edges and the zero vector
    task automatic random_lookup();
        logic signed [15:0] d [3];
        int unsigned        mode;
        int unsigned        mag;
        int unsigned        k;
        int                 i;
        mode = $urandom_range(0, 9);
        for (i = 0; i < 3; i++)
            d[i] = 16'($urandom());
        case (mode)
            4, 5: begin
                for (i = 0; i < 3; i++)
                    d[i] = 16'(int'($urandom_range(0, 8)) - 4);
            end
            6: begin
                for (i = 0; i < 3; i++)
                    d[i] = 16'(int'($urandom_range(0, 600)) - 300);
            end
            7: begin
                // equal magnitudes on some axes, smaller values on the rest, random signs
                mag = $urandom_range(1, 32768);
                for (i = 0; i < 3; i++) begin
                    if ($urandom_range(0, 2) != 0)
                        d[i] = ($urandom_range(0, 1) != 0) ? 16'(mag) : 16'(-int'(mag));
                    else
                        d[i] = 16'(int'($urandom_range(0, 2 * mag - 2)) - int'(mag) + 1);
                end
            end
            8: begin
                k    = $urandom_range(0, 2);
                d[k] = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            end
            9: begin
                if ($urandom_range(0, 1) != 0)
                    for (i = 0; i < 3; i++)
                        d[i] = '0;
            end
            default: ;
        endcase
        send_lookup(d[0], d[1], d[2]);
    endtask

    task automatic random_item();
        if ($urandom_range(0, 3) == 0)
            random_write();
        else
            random_lookup();
    endtask

    // stop offering and let every outstanding result come back, then let the pipe empty
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    // both size registers, written back to back while the block is idle
    task automatic set_face_size(input logic [cdtl_pkg::SIZE_W-1:0] w,
                                 input logic [cdtl_pkg::SIZE_W-1:0] h);
        wait_for_results();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= cdtl_pkg::REG_FACE_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= cdtl_pkg::REG_FACE_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        width_reg  = w;
        height_reg = h;
    endtask

    // ------------------------------------------------------------------
    // sink side: random stalls plus the long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served  <= holds_served + 1;
            sink_wait     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait     <= sink_wait - 1;
            m_axis_tready <= (sink_wait == 1);
        end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
            sink_wait     <= $urandom_range(1, 18);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input logic [39:0] want,
                                 input logic [39:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
    endtask

    task automatic check_field(input string what, input logic [39:0] want,
                               input logic [39:0] got);
        if (want !== got)
            note_mismatch(what, want, got);
    endtask

    // each result transaction against the oldest prediction
    always @(posedge i_clk) begin : check_results
        t_texel_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_q.size() == 0) begin
                note_mismatch("unexpected result", '0, {m_axis_tuser, m_axis_tdata[38:0]});
            end else begin
                want = expected_q.pop_front();
                check_field("color", 40'(want.color),
                            40'(m_axis_tdata[cdtl_pkg::COLOR_W-1:0]));
                check_field("face", 40'(want.face),
                            40'(m_axis_tdata[FACE_LSB +: cdtl_pkg::FACE_W]));
                check_field("col", 40'(want.col),
                            40'(m_axis_tdata[COL_LSB +: cdtl_pkg::TCOL_W]));
                check_field("row", 40'(want.row),
                            40'(m_axis_tdata[ROW_LSB +: cdtl_pkg::TCOL_W]));
                check_field("zero_dir", 40'(want.zero_dir), 40'(m_axis_tuser));
            end
        end
    end

    // watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // corner texels, extreme colors, both unused face codes (dropped)
    task automatic test_texel_writes();
        send_write(cdtl_pkg::FACE_NEG_X, 0, 0, 24'h000000);
        send_write(cdtl_pkg::FACE_POS_Z, FACE_SIZE - 1, FACE_SIZE - 1, 24'hFFFFFF);
        send_write(cdtl_pkg::FACE_W'(cdtl_pkg::NUM_FACES), 0, FACE_SIZE - 1, 24'h5A5A5A);
        send_write(cdtl_pkg::FACE_W'((1 << cdtl_pkg::FACE_W) - 1), FACE_SIZE - 1, 0,
                   24'hA5A5A5);
    endtask

    // every face, ties, most negative values, far edge clamp, zero vector
    task automatic test_direction_cases();
        send_lookup(16'sd0, 16'sd0, 16'sd0);                 // zero vector
        send_lookup(16'sd1000, 16'sd200, -16'sd300);         // positive x
        send_lookup(-16'sd1000, 16'sd200, -16'sd300);        // negative x
        send_lookup(16'sd5, -16'sd700, 16'sd9);              // negative y
        send_lookup(16'sd5, 16'sd700, 16'sd9);               // positive y
        send_lookup(-16'sd20, 16'sd30, 16'sh7FFF);           // positive z, largest value
        send_lookup(-16'sd20, 16'sd30, 16'sh8000);           // negative z, magnitude 32768
        send_lookup(16'sh8000, 16'sh8000, 16'sh8000);        // three-way tie, row at far edge
        send_lookup(16'sh7FFF, 16'sh7FFF, 16'sd0);           // x and y tie, x wins
        send_lookup(16'sd0, -16'sd500, 16'sd500);            // y and z tie, y wins
        send_lookup(16'sd100, 16'sd0, -16'sd100);            // column lands on W, clamps
        send_lookup(16'sd1, 16'sd0, 16'sd0);                 // unit vector, face center
    endtask

    // block fills up behind a stalled sink and must push back on the source
    task automatic test_output_backpressure();
        src_idle_on = 1'b0;
        hold_requests <= hold_requests + 1;
        repeat (40) random_lookup();
        src_idle_on = 1'b1;
    endtask

    // size register extremes, including zero and values past the face size
    task automatic test_size_registers();
        logic [cdtl_pkg::SIZE_W-1:0] widths  [7] = '{7'd1, 7'd0, 7'd127, 7'd65, 7'd2, 7'd37,
                                                     7'd64};
        logic [cdtl_pkg::SIZE_W-1:0] heights [7] = '{7'd1, 7'd0, 7'd127, 7'd2, 7'd65, 7'd5,
                                                     7'd64};
        int                          p;
        for (p = 0; p < 7; p++) begin
            set_face_size(widths[p], heights[p]);
            repeat (30) random_item();
        end
    endtask

    // load bursts followed by mixed traffic under random sizes
    task automatic test_random_mix();
        logic [cdtl_pkg::SIZE_W-1:0] w;
        logic [cdtl_pkg::SIZE_W-1:0] h;
        int                          p;
        for (p = 0; p < 4; p++) begin
            w = ($urandom_range(0, 3) == 0) ? cdtl_pkg::SIZE_W'($urandom_range(0, 127))
                                            : cdtl_pkg::SIZE_W'($urandom_range(1, 64));
            h = ($urandom_range(0, 3) == 0) ? cdtl_pkg::SIZE_W'($urandom_range(0, 127))
                                            : cdtl_pkg::SIZE_W'($urandom_range(1, 64));
            set_face_size(w, h);
            repeat (20) random_write();
            repeat (100) random_item();
        end
    endtask

    // back to back traffic with no idling on either side
    task automatic test_steady_stream();
        set_face_size(7'd48, 7'd20);
        sink_idle_on <= 1'b0;
        src_idle_on = 1'b0;
        repeat (100) random_item();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_texel_writes();
        test_direction_cases();
        test_output_backpressure();
        test_size_registers();
        test_random_mix();
        test_steady_stream();
        wait_for_results();
        repeat (PIPE_LATENCY) @(posedge i_clk);
        if (mismatch_count == 0 && expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/cdtl_pkg.sv
hw/rtl/cdtl_ram.sv
hw/rtl/cdtl_front.sv
hw/rtl/cdtl_div.sv
hw/rtl/cubemap_direction_texel_lookup.sv
tb/sv/tb_cubemap_direction_texel_lookup.sv
